@@ hw/rtl/uart_line_event_monitor_macros.svh @@
// Assertion macros for the port-level checker file.
`ifndef UART_LINE_EVENT_MONITOR_MACROS_SVH
`define UART_LINE_EVENT_MONITOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define ULEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define ULEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ulem_pkg.sv @@
`default_nettype none

package ulem_pkg;

    // Event codes carried in the func field
    localparam logic [2:0] FUNC_LSR   = 3'd0;
    localparam logic [2:0] FUNC_RX    = 3'd1;
    localparam logic [2:0] FUNC_MSR   = 3'd2;
    localparam logic [2:0] FUNC_TICK  = 3'd3;
    localparam logic [2:0] FUNC_TXRDY = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOFT_FLOW  = 2'd0;
    localparam logic [1:0] CFG_HUP_DSR    = 2'd1;
    localparam logic [1:0] CFG_HUP_DCD    = 2'd2;
    localparam logic [1:0] CFG_DCD_STAMP  = 2'd3;

    // Flow characters and timing
    localparam logic [7:0]  CHAR_XOFF     = 8'h13;
    localparam logic [7:0]  CHAR_XON      = 8'h11;
    localparam logic [1:0]  BACKOFF_TICKS = 2'd2;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Line status bits
    localparam int LSR_OVERRUN = 1;
    localparam int LSR_FRAMING = 3;

    // Modem status bits
    localparam int MSR_DCTS = 0;
    localparam int MSR_DDSR = 1;
    localparam int MSR_DDCD = 3;
    localparam int MSR_CTS  = 4;
    localparam int MSR_DSR  = 5;
    localparam int MSR_DCD  = 7;

    typedef struct packed {
        logic soft_flow;
        logic hup_dsr;
        logic hup_dcd;
        logic dcd_stamp;
    } t_cfg;

    typedef struct packed {
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        send_allowed;
        logic        kick;
        logic        hangup;
        logic        stamp_pulse;
        logic [15:0] framing_count;
        logic [15:0] overrun_count;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/ulem_flow.sv @@
`default_nettype none

// Line state tracker: holds modem levels, flow state and error counters,
// and forms the result word for the event presented on its inputs.
module ulem_flow
    import ulem_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [2:0] i_func,
    input  wire logic [7:0] i_value,
    input  wire t_cfg       i_cfg,
    output t_result         o_res
);

    logic        r_cts, n_cts;
    logic        r_dsr, n_dsr;
    logic        r_dcd, n_dcd;
    logic        r_blocked, n_blocked;
    logic [1:0]  r_backoff, n_backoff;
    logic        r_hup_pend, n_hup_pend;
    logic [15:0] r_frm_cnt, n_frm_cnt;
    logic [15:0] r_ovr_cnt, n_ovr_cnt;

    // Next state and result for one event
    always_comb begin
        n_cts      = r_cts;
        n_dsr      = r_dsr;
        n_dcd      = r_dcd;
        n_blocked  = r_blocked;
        n_backoff  = r_backoff;
        n_hup_pend = r_hup_pend;
        n_frm_cnt  = r_frm_cnt;
        n_ovr_cnt  = r_ovr_cnt;
        o_res      = '0;

        case (i_func)
            FUNC_LSR: begin
                if (i_value[LSR_FRAMING] && (r_frm_cnt != COUNT_MAX)) begin
                    n_frm_cnt = r_frm_cnt + 16'd1;
                end
                if (i_value[LSR_OVERRUN] && (r_ovr_cnt != COUNT_MAX)) begin
                    n_ovr_cnt = r_ovr_cnt + 16'd1;
                end
            end
            FUNC_RX: begin
                if (i_cfg.soft_flow) begin
                    if (i_value == CHAR_XOFF) begin
                        n_blocked = 1'b1;
                    end else if (i_value == CHAR_XON) begin
                        n_blocked = 1'b0;
                        n_backoff = BACKOFF_TICKS;
                    end
                end
                o_res.rx_valid = 1'b1;
                o_res.rx_byte  = i_value;
            end
            FUNC_MSR: begin
                if (i_value[MSR_DCTS]) begin
                    n_cts = i_value[MSR_CTS];
                    // CTS rising restarts output after a backoff
                    if (!r_cts && i_value[MSR_CTS]) begin
                        n_backoff = BACKOFF_TICKS;
                    end
                end
                if (i_value[MSR_DDSR]) begin
                    if (i_cfg.hup_dsr && r_dsr && !i_value[MSR_DSR]) begin
                        n_hup_pend = 1'b1;
                    end
                    n_dsr = i_value[MSR_DSR];
                end
                if (i_value[MSR_DDCD]) begin
                    if (r_dcd && !i_value[MSR_DCD]) begin
                        o_res.stamp_pulse = i_cfg.dcd_stamp;
                        if (i_cfg.hup_dcd) begin
                            n_hup_pend = 1'b1;
                        end
                    end
                    n_dcd = i_value[MSR_DCD];
                end
            end
            FUNC_TICK: begin
                o_res.hangup = r_hup_pend;
                n_hup_pend   = 1'b0;
                if (r_backoff != 2'd0) begin
                    n_backoff = r_backoff - 2'd1;
                    // tick leaves CTS and blocking alone
                    o_res.kick = (n_backoff == 2'd0) && r_cts && !r_blocked;
                end
            end
            FUNC_TXRDY: begin
                o_res.kick = r_cts && !r_blocked;
            end
            default: begin
            end
        endcase

        o_res.send_allowed  = n_cts && !n_blocked;
        o_res.framing_count = n_frm_cnt;
        o_res.overrun_count = n_ovr_cnt;
    end

    // State update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cts      <= 1'b1;
            r_dsr      <= 1'b0;
            r_dcd      <= 1'b0;
            r_blocked  <= 1'b0;
            r_backoff  <= 2'd0;
            r_hup_pend <= 1'b0;
            r_frm_cnt  <= 16'd0;
            r_ovr_cnt  <= 16'd0;
        end else if (i_accept) begin
            r_cts      <= n_cts;
            r_dsr      <= n_dsr;
            r_dcd      <= n_dcd;
            r_blocked  <= n_blocked;
            r_backoff  <= n_backoff;
            r_hup_pend <= n_hup_pend;
            r_frm_cnt  <= n_frm_cnt;
            r_ovr_cnt  <= n_ovr_cnt;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/uart_line_event_monitor.sv @@
// Channel  | Handshake                  | Word
// ---------+----------------------------+------------------------------------
// in       | i_in_valid / o_in_stall    | i_func, i_value
// out      | o_out_valid / i_out_stall  | o_rx_valid .. o_overrun_count
// cfg      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// State updates and the result register loads at the edge that accepts the
// word; the result shows on the next cycle.
// Throughput is one word per cycle while the output does not stall.
// Input stalls only while the one result register is full and the output stalls.
// Synchronous active-low reset initialises state, config and the result valid.
`default_nettype none

module uart_line_event_monitor
    import ulem_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [0:0]  i_cfg_data,
    // event input
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_value,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_rx_valid,
    output logic [7:0]       o_rx_byte,
    output logic             o_send_allowed,
    output logic             o_kick,
    output logic             o_hangup,
    output logic             o_stamp_pulse,
    output logic [15:0]      o_framing_count,
    output logic [15:0]      o_overrun_count
);

    t_cfg    r_cfg;
    t_result n_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_accept;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOFT_FLOW: r_cfg.soft_flow <= i_cfg_data[0];
                CFG_HUP_DSR:   r_cfg.hup_dsr   <= i_cfg_data[0];
                CFG_HUP_DCD:   r_cfg.hup_dcd   <= i_cfg_data[0];
                CFG_DCD_STAMP: r_cfg.dcd_stamp <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: take a word whenever the result slot frees this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    ulem_flow u_flow (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_func   (i_func),
        .i_value  (i_value),
        .i_cfg    (r_cfg),
        .o_res    (n_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rx_valid      = r_res.rx_valid;
    assign o_rx_byte       = r_res.rx_byte;
    assign o_send_allowed  = r_res.send_allowed;
    assign o_kick          = r_res.kick;
    assign o_hangup        = r_res.hangup;
    assign o_stamp_pulse   = r_res.stamp_pulse;
    assign o_framing_count = r_res.framing_count;
    assign o_overrun_count = r_res.overrun_count;

endmodule

`default_nettype wire

@@ hw/rtl/ulem_checker.sv @@
`default_nettype none
`include "uart_line_event_monitor_macros.svh"

// Port-level checks on the event monitor
module ulem_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_rx_valid,
    input wire logic [7:0]  o_rx_byte,
    input wire logic        o_send_allowed,
    input wire logic        o_kick,
    input wire logic        o_hangup,
    input wire logic        o_stamp_pulse,
    input wire logic [15:0] o_framing_count
);

    // A kick is only issued while sending is allowed
    `ULEM_ASSERT_NOW(a_kick_allowed, o_out_valid && o_kick, o_send_allowed, "kick while not allowed")

    // A received-byte word carries no other event pulse
    `ULEM_ASSERT_NOW(a_rx_alone, o_out_valid && o_rx_valid, !o_kick && !o_hangup && !o_stamp_pulse, "rx word with pulses")

    // No byte shows on non-receive words
    `ULEM_ASSERT_NOW(a_rx_byte_zero, o_out_valid && !o_rx_valid, o_rx_byte == 8'd0, "stray rx byte")

    // Every accepted word yields a result next cycle
    `ULEM_ASSERT_NEXT(a_accept_result, i_in_valid && !o_in_stall, o_out_valid, "result missing")

    // A stalled result holds
    `ULEM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_framing_count), "stalled result changed")

endmodule

bind uart_line_event_monitor ulem_checker u_ulem_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_rx_valid      (o_rx_valid),
    .o_rx_byte       (o_rx_byte),
    .o_send_allowed  (o_send_allowed),
    .o_kick          (o_kick),
    .o_hangup        (o_hangup),
    .o_stamp_pulse   (o_stamp_pulse),
    .o_framing_count (o_framing_count)
);

`default_nettype wire
